@@ hdl/bfbm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types for the block free bitmap manager: command and status codes.
// No dependencies; imported by bfbm_word_logic and block_free_bitmap_manager.
package bfbm_pkg;

    typedef enum logic [1:0] {
        CMD_FORMAT = 2'd0,
        CMD_MARK   = 2'd1,
        CMD_FREE   = 2'd2,
        CMD_FIND   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DISABLED = 2'd1,
        ST_RANGE    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

endpackage

@@ hdl/bfbm_word_logic.sv @@
`timescale 1ns / 1ps
// Per-word update and first-free search for one bitmap word of the map.
// Depends on bfbm_pkg for the command type.
module bfbm_word_logic #(
    parameter int WORD_BITS = 32,
    parameter int BLK_W     = 14
) (
    input  bfbm_pkg::cmd_t                 op,
    input  logic [BLK_W-1:0]               base,
    input  logic [BLK_W-1:0]               lo,
    input  logic [BLK_W-1:0]               hi,
    input  logic [WORD_BITS-1:0]           old_word,
    output logic [WORD_BITS-1:0]           new_word,
    output logic                           hit,
    output logic [$clog2(WORD_BITS)-1:0]   hit_idx
);
    import bfbm_pkg::*;

    localparam int IW = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] in_range;
    logic [WORD_BITS-1:0] free_bits;

    always_comb begin
        logic [BLK_W-1:0] blk;
        for (int b = 0; b < WORD_BITS; b++) begin
            blk         = base + BLK_W'(b);
            in_range[b] = (blk >= lo) && (blk < hi);
        end
    end

    always_comb begin
        case (op)
            CMD_FORMAT: new_word = in_range;
            CMD_MARK:   new_word = old_word | in_range;
            CMD_FREE:   new_word = old_word & ~in_range;
            default:    new_word = old_word;
        endcase
    end

    assign free_bits = ~old_word & in_range;
    assign hit       = |free_bits;

    always_comb begin
        hit_idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                hit_idx = IW'(b);
            end
        end
    end

endmodule

@@ hdl/block_free_bitmap_manager.sv @@
`timescale 1ns / 1ps
// Block free bitmap manager: used/free map over the disk blocks in one memory.
// Depends on bfbm_pkg and bfbm_word_logic.
//
// One bit per block (1 = used) is kept in a memory of ceil(MAX_BLOCKS /
// MAP_WORD_BITS) words, one word read and one written per cycle. After reset
// the map is cleared by a pass of one word per cycle; s_tready rises once the pass
// has ended. Configuration writes are taken at all times. One command is processed
// at a time. A refused command (volume disabled or range past the end) goes straight
// to the finish state without walking the map. Format walks every map word. Mark and
// free walk the words from word 0 up to the one holding the last block of the range,
// find walks from word 0 up to the first word with a free block below the volume
// size. The result is loaded once the previous one has been taken, s_tready rises
// together with m_tvalid, and the next command can be taken from then on.
// The rate is set by the single read-modify-write pass over the map memory,
// one word per cycle.
module block_free_bitmap_manager #(
    parameter int MAX_BLOCKS    = 4096,
    parameter int MAP_WORD_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // command[1:0], start_block[13:2], block_count[26:14]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // status[1:0], free_block[13:2], blocks_changed[26:14]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);
    import bfbm_pkg::*;

    localparam int MAP_WORDS = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CW        = $clog2(MAP_WORDS + 1);
    localparam int IW        = $clog2(MAP_WORD_BITS);
    localparam int BW_RAW    = $clog2(MAP_WORDS * MAP_WORD_BITS + MAP_WORD_BITS + 1);
    localparam int BW        = (BW_RAW > 14) ? BW_RAW : 14;
    localparam logic [13:0] MAX_CLIP = (MAX_BLOCKS > 8191) ? 14'd8191 : 14'(MAX_BLOCKS);

    localparam logic [1:0] CFG_ENABLE   = 2'd0;
    localparam logic [1:0] CFG_DISK     = 2'd1;
    localparam logic [1:0] CFG_RESERVED = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_FINISH
    } state_t;

    state_t             state_reg;
    logic               enabled_reg;
    logic [12:0]        disk_reg;
    logic [12:0]        reserved_reg;

    cmd_t               op_reg;
    logic               clear_reg;
    logic [BW-1:0]      lo_reg;
    logic [BW-1:0]      hi_reg;
    logic [CW-1:0]      cnt_reg;
    logic [BW-1:0]      base_reg;
    logic               pend_reg;
    logic [BW-1:0]      base_d_reg;
    logic [AW-1:0]      wr_addr_reg;

    status_t            status_reg;
    logic [11:0]        found_reg;
    logic [12:0]        changed_reg;

    logic               m_tvalid_reg;
    logic [31:0]        m_tdata_reg;

    logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];
    logic [MAP_WORD_BITS-1:0] rd_data_reg;

    cmd_t               in_cmd;
    logic [11:0]        in_start;
    logic [12:0]        in_count;
    logic [12:0]        limit;
    logic [12:0]        fmt_count;
    logic [13:0]        range_end;
    logic               in_fire;
    logic               issue_ok;
    logic               wr_en;
    logic               out_load;
    logic [MAP_WORD_BITS-1:0] new_word;
    logic               hit;
    logic [IW-1:0]      hit_idx;
    logic               find_hit;
    logic [BW-1:0]      hit_block;

    assign in_cmd    = cmd_t'(s_tdata[1:0]);
    assign in_start  = s_tdata[13:2];
    assign in_count  = s_tdata[26:14];

    assign limit     = ({1'b0, disk_reg} < MAX_CLIP) ? disk_reg : MAX_CLIP[12:0];
    assign fmt_count = (reserved_reg < limit) ? reserved_reg : limit;
    assign range_end = {2'b00, in_start} + {1'b0, in_count};

    assign s_tready  = (state_reg == S_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_load  = (state_reg == S_FINISH) && (!m_tvalid_reg || m_tready);

    assign issue_ok  = (state_reg == S_SWEEP) && (cnt_reg < CW'(MAP_WORDS))
                       && ((op_reg == CMD_FORMAT) || (base_reg < hi_reg));
    assign find_hit  = pend_reg && (op_reg == CMD_FIND) && hit;
    assign wr_en     = pend_reg && (op_reg != CMD_FIND);
    assign hit_block = base_d_reg + BW'(hit_idx);

    bfbm_word_logic #(
        .WORD_BITS (MAP_WORD_BITS),
        .BLK_W     (BW)
    ) u_word (
        .op       (op_reg),
        .base     (base_d_reg),
        .lo       (lo_reg),
        .hi       (hi_reg),
        .old_word (rd_data_reg),
        .new_word (new_word),
        .hit      (hit),
        .hit_idx  (hit_idx)
    );

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            map_mem[wr_addr_reg] <= new_word;
        end
        if (issue_ok && !find_hit) begin
            rd_data_reg <= map_mem[cnt_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_SWEEP;
            enabled_reg  <= 1'b0;
            disk_reg     <= 13'd4096;
            reserved_reg <= 13'd0;
            op_reg       <= CMD_FORMAT;
            clear_reg    <= 1'b1;
            lo_reg       <= '0;
            hi_reg       <= '0;
            cnt_reg      <= '0;
            base_reg     <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ENABLE:   enabled_reg  <= cfg_data[0];
                    CFG_DISK:     disk_reg     <= cfg_data;
                    CFG_RESERVED: reserved_reg <= cfg_data;
                    default:      ;
                endcase
            end

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        op_reg      <= in_cmd;
                        clear_reg   <= 1'b0;
                        cnt_reg     <= '0;
                        base_reg    <= '0;
                        pend_reg    <= 1'b0;
                        found_reg   <= '0;
                        if (!enabled_reg) begin
                            status_reg  <= ST_DISABLED;
                            changed_reg <= '0;
                            state_reg   <= S_FINISH;
                        end else begin
                            case (in_cmd)
                                CMD_FORMAT: begin
                                    lo_reg      <= '0;
                                    hi_reg      <= BW'(fmt_count);
                                    status_reg  <= ST_OK;
                                    changed_reg <= fmt_count;
                                    state_reg   <= S_SWEEP;
                                end
                                CMD_MARK, CMD_FREE: begin
                                    if (range_end > {1'b0, limit}) begin
                                        status_reg  <= ST_RANGE;
                                        changed_reg <= '0;
                                        state_reg   <= S_FINISH;
                                    end else begin
                                        lo_reg      <= BW'(in_start);
                                        hi_reg      <= BW'(range_end);
                                        status_reg  <= ST_OK;
                                        changed_reg <= in_count;
                                        state_reg   <= S_SWEEP;
                                    end
                                end
                                default: begin
                                    lo_reg      <= '0;
                                    hi_reg      <= BW'(limit);
                                    status_reg  <= ST_FULL;
                                    changed_reg <= '0;
                                    state_reg   <= S_SWEEP;
                                end
                            endcase
                        end
                    end
                end
                S_SWEEP: begin
                    if (find_hit) begin
                        status_reg <= ST_OK;
                        found_reg  <= hit_block[11:0];
                        pend_reg   <= 1'b0;
                        state_reg  <= S_FINISH;
                    end else if (issue_ok) begin
                        pend_reg    <= 1'b1;
                        cnt_reg     <= cnt_reg + CW'(1);
                        base_reg    <= base_reg + BW'(MAP_WORD_BITS);
                        base_d_reg  <= base_reg;
                        wr_addr_reg <= cnt_reg[AW-1:0];
                    end else begin
                        pend_reg <= 1'b0;
                        if (!pend_reg) begin
                            state_reg <= clear_reg ? S_IDLE : S_FINISH;
                        end
                    end
                end
                S_FINISH: begin
                    if (out_load) begin
                        m_tdata_reg <= {5'd0, changed_reg, found_reg, status_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
